[design/pit_pkg.sv]
package pit_pkg;

  // field and datapath widths
  localparam int unsigned CoordW    = 16;
  localparam int unsigned DiffW     = CoordW + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned AreaW     = ProdW + 1;
  localparam int unsigned MagW      = AreaW;
  localparam int unsigned RemW      = MagW + 1;
  localparam int unsigned TolW      = 16;
  localparam int unsigned FracW     = 16;
  localparam int unsigned WeightW   = 32;
  localparam int unsigned DivSteps  = WeightW;
  localparam int unsigned SatW      = (AreaW > WeightW) ? AreaW : WeightW + 1;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgProdTol,
    CfgAreaTol
  } cfg_idx_e;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [DiffW-1:0]   diff_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [AreaW-1:0]   area_t;
  typedef logic        [MagW-1:0]    mag_t;
  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic        [TolW-1:0]    tol_t;

  // classified item handed from front to back
  typedef struct packed {
    logic            hit;
    logic            degenerate;
    area_t [2:0]     num;
    area_t           den;
  } job_t;

  // clamp a signed area to the signed weight range
  function automatic weight_t sat_weight(input area_t v);
    logic signed [SatW-1:0] w;
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    weight_t                r;
    w  = SatW'(v);
    hi = SatW'({1'b0, {(WeightW-1){1'b1}}});
    lo = ~hi;
    if (w > hi) begin
      r = {1'b0, {(WeightW-1){1'b1}}};
    end else if (w < lo) begin
      r = {1'b1, {(WeightW-1){1'b0}}};
    end else begin
      r = w[WeightW-1:0];
    end
    return r;
  endfunction

endpackage

[design/pit_in_if.sv]
interface pit_in_if
  import pit_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t a_x, a_y, a_z;
  coord_t b_x, b_y, b_z;
  coord_t c_x, c_y, c_z;
  coord_t p_x, p_y, p_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, p_x, p_y, p_z,
    output ready
  );
endinterface

[design/pit_out_if.sv]
interface pit_out_if
  import pit_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    inside_res;
  logic    degenerate;
  weight_t weight_a;
  weight_t weight_b;
  weight_t weight_c;

  modport source (
    output valid, inside_res, degenerate, weight_a, weight_b, weight_c,
    input  ready
  );
  modport sink (
    input  valid, inside_res, degenerate, weight_a, weight_b, weight_c,
    output ready
  );
endinterface

[design/pit_cfg_if.sv]
interface pit_cfg_if
  import pit_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  tol_t               data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/pit_front.sv]
module pit_front
  import pit_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pit_in_if.sink        in_i,
  input  tol_t          prod_tol_i,
  input  tol_t          area_tol_i,
  output job_t          job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);

  // true when a pair of edge areas has a product below minus the tolerance
  function automatic logic pair_neg(input area_t x, input area_t y, input tol_t tol);
    mag_t              mx;
    mag_t              my;
    logic [2*TolW-1:0] pr;
    logic              r;
    mx = x[AreaW-1] ? mag_t'(-x) : mag_t'(x);
    my = y[AreaW-1] ? mag_t'(-y) : mag_t'(y);
    pr = (2*TolW)'(mx[TolW-1:0]) * (2*TolW)'(my[TolW-1:0]);
    if (x == '0 || y == '0 || x[AreaW-1] == y[AreaW-1]) begin
      r = 1'b0;
    end else if (mx > mag_t'(tol) || my > mag_t'(tol)) begin
      r = 1'b1;
    end else begin
      r = pr > (2*TolW)'(tol);
    end
    return r;
  endfunction

  logic       en;
  logic [4:0] vld_q;

  coord_t a[3], b[3], c[3], p[3];
  diff_t  da_q[3], db_q[3], dc_q[3], ba_q[3], ca_q[3];
  prod_t  pl_q[3][4], pr_q[3][4];
  area_t  area_q[3][4], area4_q[3][4];
  logic [2:0] negp_q[3];
  logic [2:0] nz_q;
  job_t   job_d, job_q;

  // whole front moves together unless the last stage is blocked
  assign en          = !vld_q[4] || job_ready_i;
  assign in_i.ready  = en;
  assign job_o       = job_q;
  assign job_valid_o = vld_q[4];

  assign a[0] = in_i.a_x;  assign a[1] = in_i.a_y;  assign a[2] = in_i.a_z;
  assign b[0] = in_i.b_x;  assign b[1] = in_i.b_y;  assign b[2] = in_i.b_z;
  assign c[0] = in_i.c_x;  assign c[1] = in_i.c_y;  assign c[2] = in_i.c_z;
  assign p[0] = in_i.p_x;  assign p[1] = in_i.p_y;  assign p[2] = in_i.p_z;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[3:0], in_i.valid && in_i.ready};
    end
  end

  // datapath stages: differences, products, areas, pair tests
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        da_q[j] <= diff_t'(a[j]) - diff_t'(p[j]);
        db_q[j] <= diff_t'(b[j]) - diff_t'(p[j]);
        dc_q[j] <= diff_t'(c[j]) - diff_t'(p[j]);
        ba_q[j] <= diff_t'(b[j]) - diff_t'(a[j]);
        ca_q[j] <= diff_t'(c[j]) - diff_t'(a[j]);
      end
      for (int k = 0; k < 3; k++) begin
        pl_q[k][0] <= prod_t'(db_q[k]) * prod_t'(dc_q[(k == 2) ? 0 : k + 1]);
        pr_q[k][0] <= prod_t'(db_q[(k == 2) ? 0 : k + 1]) * prod_t'(dc_q[k]);
        pl_q[k][1] <= prod_t'(dc_q[k]) * prod_t'(da_q[(k == 2) ? 0 : k + 1]);
        pr_q[k][1] <= prod_t'(dc_q[(k == 2) ? 0 : k + 1]) * prod_t'(da_q[k]);
        pl_q[k][2] <= prod_t'(da_q[k]) * prod_t'(db_q[(k == 2) ? 0 : k + 1]);
        pr_q[k][2] <= prod_t'(da_q[(k == 2) ? 0 : k + 1]) * prod_t'(db_q[k]);
        pl_q[k][3] <= prod_t'(ba_q[k]) * prod_t'(ca_q[(k == 2) ? 0 : k + 1]);
        pr_q[k][3] <= prod_t'(ba_q[(k == 2) ? 0 : k + 1]) * prod_t'(ca_q[k]);
        for (int m = 0; m < 4; m++) begin
          area_q[k][m]  <= area_t'(pl_q[k][m]) - area_t'(pr_q[k][m]);
          area4_q[k][m] <= area_q[k][m];
        end
        negp_q[k][0] <= pair_neg(area_q[k][0], area_q[k][1], prod_tol_i);
        negp_q[k][1] <= pair_neg(area_q[k][1], area_q[k][2], prod_tol_i);
        negp_q[k][2] <= pair_neg(area_q[k][2], area_q[k][0], prod_tol_i);
        nz_q[k] <= (area_q[k][3][AreaW-1] ? mag_t'(-area_q[k][3]) : mag_t'(area_q[k][3]))
                   > mag_t'(area_tol_i);
      end
      job_q <= job_d;
    end
  end

  // classify: sign tests and first usable projection
  always_comb begin
    job_d.hit        = !(|negp_q[0] || |negp_q[1] || |negp_q[2]);
    job_d.degenerate = 1'b0;
    priority if (nz_q[0]) begin
      job_d.num = {area4_q[0][2], area4_q[0][1], area4_q[0][0]};
      job_d.den = area4_q[0][3];
    end else if (nz_q[1]) begin
      job_d.num = {area4_q[1][2], area4_q[1][1], area4_q[1][0]};
      job_d.den = area4_q[1][3];
    end else if (nz_q[2]) begin
      job_d.num = {area4_q[2][2], area4_q[2][1], area4_q[2][0]};
      job_d.den = area4_q[2][3];
    end else begin
      job_d.num        = {area4_q[2][2], area4_q[2][1], area4_q[2][0]};
      job_d.den        = '0;
      job_d.degenerate = job_d.hit;
    end
  end

endmodule

[design/pit_fifo.sv]
module pit_fifo
  import pit_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  job_t                mem_q[FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != FifoCntW'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue fill level out of range");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue fill level did not follow a push");

endmodule

[design/pit_back.sv]
module pit_back
  import pit_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  pit_out_if.source res_o
);

  // signed, saturated weight from quotient magnitude
  function automatic weight_t fix_sign(input logic [WeightW-1:0] q, input logic ov,
                                       input logic neg);
    weight_t r;
    if (neg) begin
      r = (ov || q[WeightW-1]) ? {1'b1, {(WeightW-1){1'b0}}} : weight_t'(-q);
    end else begin
      r = (ov || q[WeightW-1]) ? {1'b0, {(WeightW-1){1'b1}}} : weight_t'(q);
    end
    return r;
  endfunction

  logic en;
  logic pop;
  logic [DivSteps:0] vld_q;

  logic                inside_q[DivSteps+1];
  logic                degen_q[DivSteps+1];
  weight_t             sat_q[DivSteps+1][3];
  logic                neg_q[DivSteps+1][3];
  logic                ov_q[DivSteps+1][3];
  mag_t                d_q[DivSteps+1][3];
  mag_t                r_q[DivSteps+1][3];
  logic [WeightW-1:0]  low_q[DivSteps+1][3];
  logic [WeightW-1:0]  quo_q[DivSteps+1][3];

  mag_t                n_mag[3];
  mag_t                d_mag[3];
  logic [RemW-1:0]     rr[DivSteps][3];

  logic    out_vld_q;
  logic    out_inside_q, out_degen_q;
  weight_t out_w_q[3];

  // stall everything while a finished result waits
  assign en          = !out_vld_q || res_o.ready;
  assign job_ready_o = en;
  assign pop         = en && job_valid_i;

  assign res_o.valid      = out_vld_q;
  assign res_o.inside_res = out_inside_q;
  assign res_o.degenerate = out_degen_q;
  assign res_o.weight_a   = out_w_q[0];
  assign res_o.weight_b   = out_w_q[1];
  assign res_o.weight_c   = out_w_q[2];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_mag[l] = job_i.num[l][AreaW-1] ? mag_t'(-job_i.num[l]) : mag_t'(job_i.num[l]);
      d_mag[l] = job_i.den[AreaW-1] ? mag_t'(-job_i.den) : mag_t'(job_i.den);
    end
    for (int s = 0; s < DivSteps; s++) begin
      for (int l = 0; l < 3; l++) begin
        rr[s][l] = {r_q[s][l], low_q[s][l][WeightW-1]};
      end
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[DivSteps-1:0], pop};
      out_vld_q <= vld_q[DivSteps];
    end
  end

  // operand prep, one restoring division step per stage, then result
  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q[0] <= job_i.hit;
      degen_q[0]  <= job_i.degenerate;
      for (int l = 0; l < 3; l++) begin
        sat_q[0][l] <= sat_weight(job_i.num[l]);
        neg_q[0][l] <= job_i.num[l][AreaW-1] != job_i.den[AreaW-1];
        ov_q[0][l]  <= (MagW+FracW)'(n_mag[l]) >= ((MagW+FracW)'(d_mag[l]) << FracW);
        d_q[0][l]   <= d_mag[l];
        r_q[0][l]   <= n_mag[l] >> FracW;
        low_q[0][l] <= WeightW'({n_mag[l][FracW-1:0], {(WeightW-FracW){1'b0}}});
        quo_q[0][l] <= '0;
      end
      for (int s = 1; s <= DivSteps; s++) begin
        inside_q[s] <= inside_q[s-1];
        degen_q[s]  <= degen_q[s-1];
        for (int l = 0; l < 3; l++) begin
          sat_q[s][l] <= sat_q[s-1][l];
          neg_q[s][l] <= neg_q[s-1][l];
          ov_q[s][l]  <= ov_q[s-1][l];
          d_q[s][l]   <= d_q[s-1][l];
          low_q[s][l] <= low_q[s-1][l] << 1;
          if (rr[s-1][l] >= RemW'(d_q[s-1][l])) begin
            r_q[s][l]   <= MagW'(rr[s-1][l] - RemW'(d_q[s-1][l]));
            quo_q[s][l] <= {quo_q[s-1][l][WeightW-2:0], 1'b1};
          end else begin
            r_q[s][l]   <= MagW'(rr[s-1][l]);
            quo_q[s][l] <= {quo_q[s-1][l][WeightW-2:0], 1'b0};
          end
        end
      end
      out_inside_q <= inside_q[DivSteps];
      out_degen_q  <= degen_q[DivSteps];
      for (int l = 0; l < 3; l++) begin
        if (!inside_q[DivSteps]) begin
          out_w_q[l] <= '0;
        end else if (degen_q[DivSteps]) begin
          out_w_q[l] <= sat_q[DivSteps][l];
        end else begin
          out_w_q[l] <= fix_sign(quo_q[DivSteps][l], ov_q[DivSteps][l],
                                 neg_q[DivSteps][l]);
        end
      end
    end
  end

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.inside_res) |->
      (res_o.weight_a == '0 && res_o.weight_b == '0 && res_o.weight_c == '0 &&
       !res_o.degenerate))
    else $error("outside result carries weights");

  a_degen_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.degenerate) |-> res_o.inside_res)
    else $error("degenerate flag on outside result");

  a_pop_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o) |=> vld_q[0])
    else $error("popped job lost at divider entry");

endmodule

[design/point_in_triangle_barycentric.sv]
// channel  dir  handshake      payload
// in_i     in   valid/ready    a_x..p_z, signed Q8.8 vertices and query point
// res_o    out  valid/ready    inside_res, degenerate, weight_a..c Q16.16
// cfg_i    in   valid/ready    index (0 product tolerance, 1 area tolerance), data
//
// one test accepted per cycle while nothing stalls; the path runs through 5 front stages,
// the 4-entry queue and 34 back stages of the divider
// the back is a 32-stage restoring divider, one quotient bit per stage per lane
// reset clears control state and both tolerances to zero
// a stalled result freezes the back; the front keeps going until the queue fills
module point_in_triangle_barycentric
  import pit_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pit_in_if.sink     in_i,
  pit_out_if.source  res_o,
  pit_cfg_if.sink    cfg_i
);

  tol_t prod_tol_q, area_tol_q;
  job_t front_job, back_job;
  logic front_valid, front_ready, back_valid, back_ready;

  // tolerance registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_tol_q <= '0;
      area_tol_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgProdTol) begin
        prod_tol_q <= cfg_i.data;
      end
      if (cfg_i.index == CfgAreaTol) begin
        area_tol_q <= cfg_i.data;
      end
    end
  end

  pit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .prod_tol_i  (prod_tol_q),
    .area_tol_i  (area_tol_q),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  pit_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  pit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .res_o       (res_o)
  );

endmodule
